[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sector mapper modules; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, masked while reset is high
`define R5M_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("r5m assertion failed");
// clocked check, active during reset too
`define R5M_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("r5m assertion failed");
`else
`define R5M_ASSERT(name, clk, rst, prop)
`define R5M_ASSERT_NR(name, clk, prop)
`endif
`endif

[rtl/r5m_pkg.sv]
// ----------------------------------------------------------------------------
// r5m_pkg
// Shared constants for the RAID5 sector mapper: field widths, register
// indexes, reset values and the number of division steps per stage.
// ----------------------------------------------------------------------------
package r5m_pkg;

  // division steps done by one pipeline stage
  localparam int STEP = 8;

  // fixed field widths
  localparam int PHYS_W      = 25;
  localparam int DISK_W      = 4;
  localparam int NDISK_CFG_W = 5;
  localparam int RSV_W       = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  // smallest usable disk count
  localparam int MIN_DISKS = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DISKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED  = 1'b1;

  // register reset values
  localparam logic [NDISK_CFG_W-1:0] NUM_DISKS_RST = 5'd4;
  localparam logic [RSV_W-1:0]       RESERVED_RST  = 8'd1;

endpackage

[rtl/r5m_div_stage.sv]
// ----------------------------------------------------------------------------
// r5m_div_stage
// One stage of the sector divider: STEP restoring division steps, dividend
// bits leave at the top of the word and quotient bits enter at the bottom.
// ----------------------------------------------------------------------------
module r5m_div_stage import r5m_pkg::*; #(
  parameter int W  = 32,
  parameter int DW = 5,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [DW-1:0] divisor,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [W-1:0]  word_in,
  input  logic [DW-1:0] rem_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [W-1:0]  word_out,
  output logic [DW-1:0] rem_out,
  output logic [SW-1:0] side_out
);

  logic          vld;
  logic          take;
  logic [W-1:0]  word_next;
  logic [DW-1:0] rem_next;

  // stage advances when empty or when the next stage takes its item
  assign take      = !vld || !out_stall;
  assign in_stall  = !take;
  assign out_valid = vld;

  // restoring division steps
  always_comb begin
    logic [DW:0] t;
    t         = '0;
    word_next = word_in;
    rem_next  = rem_in;
    for (int i = 0; i < STEP; i++) begin
      t         = {rem_next, word_next[W-1]};
      word_next = {word_next[W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t            = t - {1'b0, divisor};
        word_next[0] = 1'b1;
      end
      rem_next = t[DW-1:0];
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      word_out <= word_next;
      rem_out  <= rem_next;
      side_out <= side_in;
    end
  end

endmodule

[rtl/r5m_add_stage.sv]
// ----------------------------------------------------------------------------
// r5m_add_stage
// Adds the reserved metadata sectors to the quotient to form the stripe row.
// ----------------------------------------------------------------------------
module r5m_add_stage import r5m_pkg::*; #(
  parameter int QW = 25,
  parameter int WB = 32,
  parameter int DW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [QW-1:0]    quotient,
  input  logic [DW-1:0]    rem_in,
  input  logic [RSV_W-1:0] rsv,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WB-1:0]    row,
  output logic [DW-1:0]    data_raw
);

  logic vld;
  logic take;

  assign take      = !vld || !out_stall;
  assign in_stall  = !take;
  assign out_valid = vld;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= in_valid;
    end
  end

  // stripe row and data disk before the parity bump
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      row      <= WB'(quotient) + WB'(rsv);
      data_raw <= rem_in;
    end
  end

endmodule

[rtl/r5m_mod_stage.sv]
// ----------------------------------------------------------------------------
// r5m_mod_stage
// One stage of the row modulo chain: STEP remainder steps; the row word
// rotates so it comes out of the chain unchanged.
// ----------------------------------------------------------------------------
module r5m_mod_stage import r5m_pkg::*; #(
  parameter int W  = 32,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [DW-1:0] divisor,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [W-1:0]  word_in,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] data_in,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [W-1:0]  word_out,
  output logic [DW-1:0] rem_out,
  output logic [DW-1:0] data_out
);

  logic          vld;
  logic          take;
  logic [W-1:0]  word_next;
  logic [DW-1:0] rem_next;

  assign take      = !vld || !out_stall;
  assign in_stall  = !take;
  assign out_valid = vld;

  // remainder steps, word rotated left one bit per step
  always_comb begin
    logic [DW:0] t;
    t         = '0;
    word_next = word_in;
    rem_next  = rem_in;
    for (int i = 0; i < STEP; i++) begin
      t         = {rem_next, word_next[W-1]};
      word_next = {word_next[W-2:0], word_next[W-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[DW-1:0];
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      word_out <= word_next;
      rem_out  <= rem_next;
      data_out <= data_in;
    end
  end

endmodule

[rtl/r5m_out_stage.sv]
// ----------------------------------------------------------------------------
// r5m_out_stage
// Output register: bumps the data disk past the parity disk and trims the
// fields to their port widths.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module r5m_out_stage import r5m_pkg::*; #(
  parameter int WB = 32,
  parameter int DW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WB-1:0]     row,
  input  logic [DW-1:0]     parity_raw,
  input  logic [DW-1:0]     data_raw,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PHYS_W-1:0] physical_sector,
  output logic [DISK_W-1:0] data_disk,
  output logic [DISK_W-1:0] parity_drive
);

  logic                     vld;
  logic                     take;
  logic [WB+PHYS_W-1:0]     row_ext;
  logic [DW:0]              data_next;
  logic [DW:0]              data_full;
  logic [DW-1:0]            parity_full;
  logic [DW+DISK_W:0]       data_ext;
  logic [DW+DISK_W-1:0]     parity_ext;

  assign take      = !vld || !out_stall;
  assign in_stall  = !take;
  assign out_valid = vld;

  // data disk skips over the parity disk of its row
  assign data_next = (DW+1)'(data_raw) + (DW+1)'(data_raw >= parity_raw);
  assign row_ext   = (WB+PHYS_W)'(row);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= in_valid;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      physical_sector <= row_ext[PHYS_W-1:0];
      data_full       <= data_next;
      parity_full     <= parity_raw;
    end
  end

  // trim disk indexes to the port width
  assign data_ext     = (DW+1+DISK_W)'(data_full);
  assign parity_ext   = (DW+DISK_W)'(parity_full);
  assign data_disk    = data_ext[DISK_W-1:0];
  assign parity_drive = parity_ext[DISK_W-1:0];

  // checks
  `R5M_ASSERT_NR(a_rst_empties, clk, rst |=> !out_valid)
  `R5M_ASSERT(a_data_not_parity, clk, rst, out_valid |-> (data_full != (DW+1)'(parity_full)))

endmodule

[rtl/raid5_sector_mapper_top.sv]
// ----------------------------------------------------------------------------
// raid5_sector_mapper_top
// RAID5 rotating parity address mapper: logical sector in, physical sector,
// data disk and parity disk out.
// ----------------------------------------------------------------------------
// The mapper takes one logical sector per cycle while in_stall is low and
// returns its results in order, one per item, through ceil(LOGICAL_BITS/8)
// divide stages, one add stage, ceil((LOGICAL_BITS+1)/8) modulo stages and
// one output register. Each divide and modulo stage performs eight restoring
// steps on the narrow remainder, which sets the per-stage depth. The row is
// logical_sector / (disks - 1) plus the reserved sectors; parity rotates as
// row mod disks; a disk count below 3 acts as 3 and one above MAX_DISKS acts
// as MAX_DISKS. No range check is done. Configuration registers must only be
// written while no item is in the pipeline.
`include "assert_macros.svh"
module raid5_sector_mapper_top import r5m_pkg::*; #(
  parameter int MAX_DISKS    = 16,
  parameter int LOGICAL_BITS = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LOGICAL_BITS-1:0] logical_sector,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PHYS_W-1:0]       physical_sector,
  output logic [DISK_W-1:0]       data_disk,
  output logic [DISK_W-1:0]       parity_drive
);

  localparam int DW  = $clog2(MAX_DISKS + 1);
  localparam int NDW = (DW > NDISK_CFG_W) ? DW : NDISK_CFG_W;
  localparam int NA  = (LOGICAL_BITS + STEP - 1) / STEP;
  localparam int WA  = NA * STEP;
  localparam int RW  = LOGICAL_BITS + 1;
  localparam int NB  = (RW + STEP - 1) / STEP;
  localparam int WB  = NB * STEP;

  logic [NDISK_CFG_W-1:0] num_disks;
  logic [RSV_W-1:0]       reserved_sectors;
  logic [NDW-1:0]         nd_ext;
  logic [NDW-1:0]         nd_clamp;
  logic [DW-1:0]          disks;
  logic [DW-1:0]          per_row;

  logic             a_vld   [NA+1];
  logic             a_stall [NA+1];
  logic [WA-1:0]    a_word  [NA+1];
  logic [DW-1:0]    a_rem   [NA+1];
  logic [RSV_W-1:0] a_rsv   [NA+1];

  logic             b_vld   [NB+1];
  logic             b_stall [NB+1];
  logic [WB-1:0]    b_word  [NB+1];
  logic [DW-1:0]    b_rem   [NB+1];
  logic [DW-1:0]    b_data  [NB+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_disks        <= NUM_DISKS_RST;
      reserved_sectors <= RESERVED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NUM_DISKS: num_disks        <= cfg_data[NDISK_CFG_W-1:0];
        REG_RESERVED:  reserved_sectors <= cfg_data[RSV_W-1:0];
      endcase
    end
  end

  // saturate the disk count to the supported range
  always_comb begin
    nd_ext = NDW'(num_disks);
    if (nd_ext < NDW'(MIN_DISKS)) begin
      nd_clamp = NDW'(MIN_DISKS);
    end else if (nd_ext > NDW'(MAX_DISKS)) begin
      nd_clamp = NDW'(MAX_DISKS);
    end else begin
      nd_clamp = nd_ext;
    end
  end

  assign disks   = nd_clamp[DW-1:0];
  assign per_row = disks - DW'(1);

  // input side of the divide chain
  assign a_vld[0]  = in_valid;
  assign in_stall  = a_stall[0];
  assign a_word[0] = WA'(logical_sector);
  assign a_rem[0]  = '0;
  assign a_rsv[0]  = reserved_sectors;

  // logical sector / (disks - 1)
  for (genvar g = 0; g < NA; g++) begin : g_div
    r5m_div_stage #(
      .W  (WA),
      .DW (DW),
      .SW (RSV_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .divisor   (per_row),
      .in_valid  (a_vld[g]),
      .in_stall  (a_stall[g]),
      .word_in   (a_word[g]),
      .rem_in    (a_rem[g]),
      .side_in   (a_rsv[g]),
      .out_valid (a_vld[g+1]),
      .out_stall (a_stall[g+1]),
      .word_out  (a_word[g+1]),
      .rem_out   (a_rem[g+1]),
      .side_out  (a_rsv[g+1])
    );
  end

  // stripe row
  r5m_add_stage #(
    .QW (LOGICAL_BITS),
    .WB (WB),
    .DW (DW)
  ) u_add (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_vld[NA]),
    .in_stall  (a_stall[NA]),
    .quotient  (a_word[NA][LOGICAL_BITS-1:0]),
    .rem_in    (a_rem[NA]),
    .rsv       (a_rsv[NA]),
    .out_valid (b_vld[0]),
    .out_stall (b_stall[0]),
    .row       (b_word[0]),
    .data_raw  (b_data[0])
  );

  assign b_rem[0] = '0;

  // row mod disks
  for (genvar g = 0; g < NB; g++) begin : g_mod
    r5m_mod_stage #(
      .W  (WB),
      .DW (DW)
    ) u_mod (
      .clk       (clk),
      .rst       (rst),
      .divisor   (disks),
      .in_valid  (b_vld[g]),
      .in_stall  (b_stall[g]),
      .word_in   (b_word[g]),
      .rem_in    (b_rem[g]),
      .data_in   (b_data[g]),
      .out_valid (b_vld[g+1]),
      .out_stall (b_stall[g+1]),
      .word_out  (b_word[g+1]),
      .rem_out   (b_rem[g+1]),
      .data_out  (b_data[g+1])
    );
  end

  // output register
  r5m_out_stage #(
    .WB (WB),
    .DW (DW)
  ) u_out (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (b_vld[NB]),
    .in_stall        (b_stall[NB]),
    .row             (b_word[NB]),
    .parity_raw      (b_rem[NB]),
    .data_raw        (b_data[NB]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .physical_sector (physical_sector),
    .data_disk       (data_disk),
    .parity_drive    (parity_drive)
  );

  // the input only stalls when every stage is full behind a stalled output
  `R5M_ASSERT(a_stall_chain, clk, rst, in_stall |-> (out_valid && out_stall))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RAID5 sector mapper. A stimulus table covers
// reset settings, field extremes and disk count saturation. Random sectors
// follow in several phases, each with its own array geometry and one of four
// mixes of sender gaps and receiver stalls. Every accepted result is checked
// in order against its table entry or a local address mapping model.
// ----------------------------------------------------------------------------
module tb;
  import r5m_pkg::*;

  localparam int SECTOR_W       = 25;
  localparam int MAX_DISK_COUNT = 16;
  localparam int PIPE_DEPTH     = 14;
  localparam int HANG_LIMIT     = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 236;
  localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic [DISK_W-1:0] data;
    logic [DISK_W-1:0] parity;
  } sector_map_t;

  typedef struct {
    logic [NDISK_CFG_W-1:0] disks;
    logic [RSV_W-1:0]       reserved;
    logic [SECTOR_W-1:0]    sector;
    bit                     typed;
    sector_map_t            want;
  } map_case_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_DISKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SECTOR_W-1:0]   logical_sector = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PHYS_W-1:0]     physical_sector;
  logic [DISK_W-1:0]     data_disk;
  logic [DISK_W-1:0]     parity_drive;

  // local copy of the array geometry registers
  logic [NDISK_CFG_W-1:0] geo_disks = NUM_DISKS_RST;
  logic [RSV_W-1:0]       geo_reserved = RESERVED_RST;

  sector_map_t pending_maps[$];
  map_case_t   map_cases[$];
  int          mismatches = 0;
  int          hang_cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  raid5_sector_mapper_top #(
    .MAX_DISKS    (MAX_DISK_COUNT),
    .LOGICAL_BITS (SECTOR_W)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .logical_sector  (logical_sector),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .physical_sector (physical_sector),
    .data_disk       (data_disk),
    .parity_drive    (parity_drive)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // rotating parity mapping of one logical sector
  function automatic sector_map_t map_sector(input logic [SECTOR_W-1:0] sector);
    longint unsigned disks;
    longint unsigned per_row;
    longint unsigned row;
    longint unsigned lane;
    longint unsigned par;
    sector_map_t m;
    disks = geo_disks;
    if (disks < MIN_DISKS) disks = MIN_DISKS;
    if (disks > MAX_DISK_COUNT) disks = MAX_DISK_COUNT;
    per_row = disks - 1;
    row = longint'(sector) / per_row + geo_reserved;
    par = row % disks;
    lane = longint'(sector) % per_row;
    if (lane >= par) lane = lane + 1;
    m.phys = row[PHYS_W-1:0];
    m.data = lane[DISK_W-1:0];
    m.parity = par[DISK_W-1:0];
    return m;
  endfunction

  // random sector, weighted toward both ends of the range
  function automatic logic [SECTOR_W-1:0] pick_sector();
    logic [SECTOR_W-1:0] s;
    case ($urandom_range(9))
      0: begin
        s = SECTOR_W'($urandom_range(63));
      end
      1: begin
        s = SECTOR_MAX - SECTOR_W'($urandom_range(63));
      end
      default: begin
        s = SECTOR_W'($urandom);
      end
    endcase
    return s;
  endfunction

  // register write, one cycle of write enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    if (idx == REG_NUM_DISKS) begin
      geo_disks = value[NDISK_CFG_W-1:0];
    end else begin
      geo_reserved = value[RSV_W-1:0];
    end
  endtask

  // new array geometry, unused data bits randomized
  task automatic set_geometry(input logic [NDISK_CFG_W-1:0] disks,
                              input logic [RSV_W-1:0] reserved);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom);
    value[NDISK_CFG_W-1:0] = disks;
    write_reg(REG_NUM_DISKS, value);
    write_reg(REG_RESERVED, reserved);
  endtask

  // offer one sector and queue its expected mapping on acceptance
  task automatic send_sector(input logic [SECTOR_W-1:0] sector, input sector_map_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    logical_sector <= sector;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_maps.push_back(want);
    @(negedge clk);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic add_case(input int disks, input int reserved, input logic [SECTOR_W-1:0] sector,
                          input bit typed, input int phys, input int data, input int parity);
    map_case_t c;
    c.disks = disks[NDISK_CFG_W-1:0];
    c.reserved = reserved[RSV_W-1:0];
    c.sector = sector;
    c.typed = typed;
    c.want.phys = phys[PHYS_W-1:0];
    c.want.data = data[DISK_W-1:0];
    c.want.parity = parity[DISK_W-1:0];
    map_cases.push_back(c);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    sector_map_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_maps.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: phys %0d data %0d parity %0d",
                   physical_sector, data_disk, parity_drive);
        mismatches = mismatches + 1;
      end else begin
        want = pending_maps.pop_front();
        if (physical_sector !== want.phys || data_disk !== want.data ||
            parity_drive !== want.parity) begin
          if (mismatches < 10)
            $display("mismatch: expected phys %0d data %0d parity %0d, got %0d %0d %0d",
                     want.phys, want.data, want.parity,
                     physical_sector, data_disk, parity_drive);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    // reset geometry, low and high sectors
    add_case(4, 1, 0, 1, 1, 0, 1);
    add_case(4, 1, 1, 1, 1, 2, 1);
    add_case(4, 1, 2, 1, 1, 3, 1);
    add_case(4, 1, 3, 1, 2, 0, 2);
    add_case(4, 1, SECTOR_MAX, 1, 11184811, 1, 3);
    // smallest array
    add_case(3, 0, 0, 1, 0, 1, 0);
    add_case(3, 0, 1, 1, 0, 2, 0);
    add_case(3, 0, SECTOR_MAX, 1, 16777215, 2, 0);
    // disk counts below the minimum act as three
    add_case(0, 255, 0, 1, 255, 1, 0);
    add_case(0, 255, SECTOR_MAX, 0, 0, 0, 0);
    add_case(2, 255, 5, 0, 0, 0, 0);
    add_case(1, 7, 7, 0, 0, 0, 0);
    // widest array
    add_case(16, 0, 0, 1, 0, 1, 0);
    add_case(16, 0, 14, 1, 0, 15, 0);
    add_case(16, 0, 15, 1, 1, 0, 1);
    add_case(16, 0, SECTOR_MAX, 0, 0, 0, 0);
    // disk counts above the maximum act as sixteen
    add_case(31, 255, 0, 1, 255, 0, 15);
    add_case(31, 255, 14, 1, 255, 14, 15);
    add_case(31, 255, SECTOR_MAX, 0, 0, 0, 0);
    add_case(17, 128, 25'h1555555, 0, 0, 0, 0);
    add_case(17, 128, 25'h0AAAAAA, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (map_cases[i]) begin
      if (map_cases[i].disks != geo_disks || map_cases[i].reserved != geo_reserved) begin
        wait_drained();
        set_geometry(map_cases[i].disks, map_cases[i].reserved);
      end
      if (map_cases[i].typed) begin
        send_sector(map_cases[i].sector, map_cases[i].want);
      end else begin
        send_sector(map_cases[i].sector, map_sector(map_cases[i].sector));
      end
    end

    // random phases, each with its own geometry and one of four idle mixes
    for (int p = 0; p < PHASES; p++) begin
      logic [SECTOR_W-1:0] s;
      wait_drained();
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 55;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 55;
        end
        default: begin
          gap_pct = 8;
          stall_pct = 8;
        end
      endcase
      if (p == 0) begin
        set_geometry(3, 0);
      end else if (p == 1) begin
        set_geometry(16, 255);
      end else if ($urandom_range(3) == 0) begin
        set_geometry(NDISK_CFG_W'($urandom_range(31)), RSV_W'($urandom_range(255)));
      end else begin
        set_geometry(NDISK_CFG_W'($urandom_range(16, 3)), RSV_W'($urandom_range(255)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = pick_sector();
        send_sector(s, map_sector(s));
      end
    end

    wait_drained();
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/r5m_pkg.sv
rtl/r5m_div_stage.sv
rtl/r5m_add_stage.sv
rtl/r5m_mod_stage.sv
rtl/r5m_out_stage.sv
rtl/raid5_sector_mapper_top.sv
tb/tb.sv
